// ===== src/imu_fp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_pkg
// Shared types and constants of the IMU frame parser: frame geometry,
// header byte, register indexes, kind codes and the structs that pass
// between the window, the scaler and the top level.
// ----------------------------------------------------------------------------
package imu_fp_pkg;

	// Frame geometry
	localparam int FRAME_BYTES = 11;
	localparam int HOLD_BYTES  = FRAME_BYTES - 1;
	localparam int FILL_W      = $clog2(FRAME_BYTES);

	localparam logic [7:0] HEADER_BYTE = 8'h55;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_TYPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_TYPE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TYPE = 2'd2;

	// Configuration reset values
	localparam logic [7:0] ACCEL_TYPE_RST = 8'd81;
	localparam logic [7:0] RATE_TYPE_RST  = 8'd82;
	localparam logic [7:0] ANGLE_TYPE_RST = 8'd83;

	// Result kind codes
	localparam logic [1:0] KIND_ACCEL = 2'd0;
	localparam logic [1:0] KIND_RATE  = 2'd1;
	localparam logic [1:0] KIND_ANGLE = 2'd2;

	// Field widths
	localparam int AXIS_W = 28;
	localparam int ADJ_W  = 26;

	typedef struct packed {
		logic [7:0] accel_code;
		logic [7:0] rate_code;
		logic [7:0] angle_code;
	} cfg_t;

	// Frame seen by the window: hit means header and checksum both matched
	typedef struct packed {
		logic               hit;
		logic [7:0]         ftype;
		logic signed [15:0] raw_x;
		logic signed [15:0] raw_y;
		logic signed [15:0] raw_z;
	} frame_t;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic signed [AXIS_W-1:0] axis_z;
		logic signed [ADJ_W-1:0]  adj;
	} result_t;

endpackage

// ===== src/imu_fp_rx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_rx_if
// Byte channel into the parser: valid/ready handshake, one received byte
// and the end-of-burst mark per item.
// ----------------------------------------------------------------------------
interface imu_fp_rx_if
	import imu_fp_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       buffer_end;

	modport source (output valid, output rx_byte, output buffer_end, input ready);
	modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// ===== src/imu_fp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_res_if
// Result channel out of the parser: valid/ready handshake and one decoded
// frame per item, axes in Q12.16.
// ----------------------------------------------------------------------------
interface imu_fp_res_if
	import imu_fp_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [1:0]               frame_kind;
	logic signed [AXIS_W-1:0] axis_x;
	logic signed [AXIS_W-1:0] axis_y;
	logic signed [AXIS_W-1:0] axis_z;
	logic signed [ADJ_W-1:0]  adjusted_third;

	modport source (
		output valid, output frame_kind, output axis_x, output axis_y,
		output axis_z, output adjusted_third, input ready
	);
	modport sink (
		input valid, input frame_kind, input axis_x, input axis_y,
		input axis_z, input adjusted_third, output ready
	);
endinterface

// ===== src/imu_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser
// Streaming parser for 11-byte IMU frames with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle, back to back, as long as its
// results are taken when offered. A byte is first held in an input register;
// while the result register is free it is added to the window and, if it
// completes a frame with a 0x55 header and a matching sum, the decoded frame
// is written to the result register, which offers it. The window advances
// only while the result register is free: while a decoded result waits at
// the output the window holds, the input register takes one more byte, and
// then the input stalls until the result is taken. Frames whose type byte
// matches none of the three type registers are consumed without a result.
// The type registers are written through the plain write port. The user must
// write them only while the parser is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module imu_frame_parser
	import imu_fp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	imu_fp_rx_if.sink            rx,
	imu_fp_res_if.source         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       out_free;
	logic       fire;
	logic       known;
	frame_t     frame;
	result_t    res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_code <= ACCEL_TYPE_RST;
			cfg_q.rate_code  <= RATE_TYPE_RST;
			cfg_q.angle_code <= ANGLE_TYPE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACCEL_TYPE: cfg_q.accel_code <= cfg_data;
				CFG_RATE_TYPE:  cfg_q.rate_code  <= cfg_data;
				CFG_ANGLE_TYPE: cfg_q.angle_code <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage advances whenever the result register can
	assign out_free = !valid_s2 || result.ready;
	assign fire     = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
			end_s1  <= rx.buffer_end;
		end
	end

	imu_fp_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.rx_byte    (byte_s1),
		.buffer_end (end_s1),
		.frame      (frame)
	);

	imu_fp_scale u_scale (
		.frame (frame),
		.cfg   (cfg_q),
		.known (known),
		.res   (res)
	);

	// Result register: load a decoded frame, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && frame.hit && known) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && frame.hit && known) begin
			res_s2 <= res;
		end
	end

	assign result.valid          = valid_s2;
	assign result.frame_kind     = res_s2.kind;
	assign result.axis_x         = res_s2.axis_x;
	assign result.axis_y         = res_s2.axis_y;
	assign result.axis_z         = res_s2.axis_z;
	assign result.adjusted_third = res_s2.adj;

endmodule

// ===== src/imu_fp_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_window
// Sliding byte window with a running 8-bit sum. The ten oldest bytes are
// held; the eleventh is the incoming byte, so a full frame is checked in
// the cycle its last byte is processed.
// ----------------------------------------------------------------------------
module imu_fp_window
	import imu_fp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] rx_byte,
	input  logic       buffer_end,
	output frame_t     frame
);

	logic [7:0]        win_q [HOLD_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        sum_q;
	logic              full;
	logic              good;

	// Check the frame formed by the held bytes and the incoming byte
	assign full = (fill_q == FILL_W'(HOLD_BYTES));
	assign good = full && (win_q[0] == HEADER_BYTE) && (sum_q == rx_byte);

	assign frame = {good, win_q[1], win_q[3], win_q[2], win_q[5], win_q[4],
		win_q[7], win_q[6]};

	// Append, or shift out the oldest byte when the frame fails
	always_ff @(posedge clk) begin
		if (fire) begin
			if (!full) begin
				for (int i = 0; i < HOLD_BYTES; i++) begin
					if (fill_q == FILL_W'(i)) begin
						win_q[i] <= rx_byte;
					end
				end
			end else if (!good) begin
				for (int i = 0; i < HOLD_BYTES - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[HOLD_BYTES-1] <= rx_byte;
			end
		end
	end

	// Track fill level and sum of the held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (fire) begin
			if (buffer_end || good) begin
				fill_q <= '0;
				sum_q  <= '0;
			end else if (!full) begin
				fill_q <= fill_q + FILL_W'(1);
				sum_q  <= sum_q + rx_byte;
			end else begin
				sum_q  <= sum_q - win_q[0] + rx_byte;
			end
		end
	end

endmodule

// ===== src/imu_fp_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_scale
// Type match and fixed-point scaling of a checked frame. Each scale is an
// exact constant product giving Q12.16 directly.
// ----------------------------------------------------------------------------
module imu_fp_scale
	import imu_fp_pkg::*;
(
	input  frame_t  frame,
	input  cfg_t    cfg,
	output logic    known,
	output result_t res
);

	localparam logic signed [AXIS_W-1:0] ACCEL_SCALE  = 28'sd32;
	localparam logic signed [AXIS_W-1:0] RATE_SCALE   = 28'sd4000;
	localparam logic signed [AXIS_W-1:0] ANGLE_SCALE  = 28'sd360;
	localparam logic signed [AXIS_W-1:0] ANGLE_OFFSET = 28'sd11796480;

	logic signed [AXIS_W-1:0] ext_x, ext_y, ext_z;
	logic signed [AXIS_W-1:0] scale;
	logic [1:0]               kind;
	logic signed [AXIS_W-1:0] sx;
	logic signed [AXIS_W-1:0] sy;
	logic signed [AXIS_W-1:0] sz;
	logic signed [AXIS_W-1:0] sz_off;
	logic signed [ADJ_W-1:0]  adj;

	assign ext_x = AXIS_W'(frame.raw_x);
	assign ext_y = AXIS_W'(frame.raw_y);
	assign ext_z = AXIS_W'(frame.raw_z);

	// Pick kind and scale; accel wins over rate, rate over angle
	always_comb begin
		known = 1'b1;
		kind  = KIND_ACCEL;
		scale = ACCEL_SCALE;
		if (frame.ftype == cfg.accel_code) begin
			kind  = KIND_ACCEL;
			scale = ACCEL_SCALE;
		end else if (frame.ftype == cfg.rate_code) begin
			kind  = KIND_RATE;
			scale = RATE_SCALE;
		end else if (frame.ftype == cfg.angle_code) begin
			kind  = KIND_ANGLE;
			scale = ANGLE_SCALE;
		end else begin
			known = 1'b0;
		end
	end

	// Scale the three axes
	assign sx     = AXIS_W'(ext_x * scale);
	assign sy     = AXIS_W'(ext_y * scale);
	assign sz     = AXIS_W'(ext_z * scale);
	assign sz_off = sz - ANGLE_OFFSET;

	// Third-axis adjustment per kind
	always_comb begin
		case (kind)
			KIND_ACCEL: adj = sz[ADJ_W-1:0];
			KIND_RATE:  adj = '0;
			KIND_ANGLE: adj = sz_off[ADJ_W-1:0];
			default:    adj = '0;
		endcase
	end

	assign res = {kind, sx, sy, sz, adj};

endmodule

// ===== src/imu_fp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_fp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module imu_fp_checker
	import imu_fp_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     res_valid,
	input logic                     res_ready,
	input logic [1:0]               frame_kind,
	input logic signed [AXIS_W-1:0] axis_x,
	input logic signed [AXIS_W-1:0] axis_y,
	input logic signed [AXIS_W-1:0] axis_z,
	input logic signed [ADJ_W-1:0]  adjusted_third
);

	// Hold a stalled result
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(frame_kind) && $stable(axis_x) &&
			$stable(axis_y) && $stable(axis_z) && $stable(adjusted_third))
		else $error("result payload changed while stalled");

	// Rate frames carry no third-axis adjustment
	a_rate_adj: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_kind == KIND_RATE |-> adjusted_third == '0)
		else $error("rate frame with nonzero adjusted_third");

	// Acceleration frames copy the z axis
	a_accel_adj: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_kind == KIND_ACCEL |-> adjusted_third == axis_z[ADJ_W-1:0])
		else $error("acceleration frame adjusted_third differs from axis_z");

endmodule

bind imu_frame_parser imu_fp_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.frame_kind     (result.frame_kind),
	.axis_x         (result.axis_x),
	.axis_y         (result.axis_y),
	.axis_z         (result.axis_z),
	.adjusted_third (result.adjusted_third)
);
